// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Plain property, clocked on clk_i and quiet during reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg
// Types, constants, coefficient builder and microcode for the shake detector.
// ----------------------------------------------------------------------------
package asd_pkg;

  // Field and register widths
  localparam int TimeW    = 48;
  localparam int MsW      = 32;
  localparam int ResSqW   = 34;
  localparam int ThrW     = 15;
  localparam int WinW     = 16;
  localparam int JoltW    = 8;
  localparam int CoolW    = 16;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 2;
  localparam int CoefW    = 16;

  // Register reset values
  localparam logic [ThrW-1:0]  ShakeThrReset   = 15'd3584;
  localparam logic [WinW-1:0]  WindowMsReset   = 16'd600;
  localparam logic [JoltW-1:0] MinJoltsReset   = 8'd3;
  localparam logic [CoolW-1:0] CooldownMsReset = 16'd800;

  // Time step handling
  localparam int unsigned DefaultStepMs = 4;
  localparam int unsigned MaxStepUs     = 200000;
  localparam int unsigned HalfMsUs      = 500;

  // Divide by 1000 as multiply by reciprocal: exact for x below 2^26
  localparam int DivXW        = 26;
  localparam int DivMulW      = 27;
  localparam int Div1000Shift = 36;
  localparam int DigitW       = 16;
  localparam int RemW         = 10;
  localparam logic [DivMulW-1:0] Div1000Mul = 27'd68719477;

  localparam logic [ResSqW-1:0] ResSqMax = {ResSqW{1'b1}};
  localparam logic [JoltW-1:0]  JoltMax  = {JoltW{1'b1}};

  // exp(-2*pi*1.2/1000) in Q0.32
  localparam logic [63:0] CoeffRatioQ32 = 64'd4262705781;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD,
    CFG_WINDOW,
    CFG_MIN_JOLTS,
    CFG_COOLDOWN
  } cfg_reg_e;

  // Microcode program counter and step addresses
  localparam int PcW = 5;
  localparam logic [PcW-1:0] StepDt    = 5'd0;
  localparam logic [PcW-1:0] StepDivDt = 5'd1;
  localparam logic [PcW-1:0] StepIdx   = 5'd2;
  localparam logic [PcW-1:0] StepDivT  = 5'd3;
  localparam logic [PcW-1:0] StepDigit = 5'd4;
  localparam logic [PcW-1:0] StepPrime = 5'd5;
  localparam logic [PcW-1:0] StepDiff  = 5'd6;
  localparam logic [PcW-1:0] StepFmul  = 5'd7;
  localparam logic [PcW-1:0] StepGupd  = 5'd8;
  localparam logic [PcW-1:0] StepRes   = 5'd9;
  localparam logic [PcW-1:0] StepSq    = 5'd10;
  localparam logic [PcW-1:0] StepAcc   = 5'd11;
  localparam logic [PcW-1:0] StepThr   = 5'd12;
  localparam logic [PcW-1:0] StepCmp   = 5'd13;
  localparam logic [PcW-1:0] StepWin   = 5'd14;
  localparam logic [PcW-1:0] StepShk   = 5'd15;
  localparam logic [PcW-1:0] StepDone  = 5'd16;

  // Datapath register action of a step
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_DT,
    ACT_IDX,
    ACT_DIGIT,
    ACT_PRIME,
    ACT_DIFF,
    ACT_GUPD,
    ACT_RES,
    ACT_ACC,
    ACT_CMP,
    ACT_WIN,
    ACT_SHK,
    ACT_DONE
  } act_e;

  // Shared multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FILT,
    MUL_SQ,
    MUL_DIV,
    MUL_THR
  } mul_e;

  // Jump conditions
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_UNPRIMED,
    JMP_DIGIT_MORE,
    JMP_AXIS_MORE,
    JMP_UNDER,
    JMP_WAIT_OUT
  } jmp_e;

  typedef struct packed {
    act_e           act;
    mul_e           mul;
    jmp_e           jmp;
    logic [PcW-1:0] target;
  } ctrl_t;

  // Control store
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t c;
    c = '{act: ACT_NONE, mul: MUL_NONE, jmp: JMP_NEXT, target: StepDt};
    unique case (pc)
      StepDt:    c.act = ACT_DT;
      StepDivDt: c.mul = MUL_DIV;
      StepIdx:   c.act = ACT_IDX;
      StepDivT:  c.mul = MUL_DIV;
      StepDigit: c = '{act: ACT_DIGIT, mul: MUL_NONE, jmp: JMP_DIGIT_MORE, target: StepDivT};
      StepPrime: c = '{act: ACT_PRIME, mul: MUL_NONE, jmp: JMP_UNPRIMED, target: StepDone};
      StepDiff:  c.act = ACT_DIFF;
      StepFmul:  c.mul = MUL_FILT;
      StepGupd:  c.act = ACT_GUPD;
      StepRes:   c.act = ACT_RES;
      StepSq:    c.mul = MUL_SQ;
      StepAcc:   c = '{act: ACT_ACC, mul: MUL_NONE, jmp: JMP_AXIS_MORE, target: StepDiff};
      StepThr:   c.mul = MUL_THR;
      StepCmp:   c = '{act: ACT_CMP, mul: MUL_NONE, jmp: JMP_UNDER, target: StepDone};
      StepWin:   c.act = ACT_WIN;
      StepShk:   c.act = ACT_SHK;
      StepDone:  c = '{act: ACT_DONE, mul: MUL_NONE, jmp: JMP_WAIT_OUT, target: StepDone};
      default:   c = '{act: ACT_NONE, mul: MUL_NONE, jmp: JMP_NEXT, target: StepDt};
    endcase
    return c;
  endfunction

  // Coefficient entry n, Q0.16: 1 - R^n built by the rounded recurrence
  function automatic logic [CoefW-1:0] coeff_entry(input int unsigned n);
    logic [63:0] p;
    logic [63:0] k;
    p = 64'h1_0000_0000;
    for (int unsigned i = 0; i < n; i++) begin
      p = (p * CoeffRatioQ32 + 64'h8000_0000) >> 32;
    end
    k = (64'h1_0000_0000 - p + 64'd32768) >> 16;
    return (k > 64'd65535) ? {CoefW{1'b1}} : k[CoefW-1:0];
  endfunction

endpackage

// File: rtl/accel_shake_detector_top.sv
// ----------------------------------------------------------------------------
// accel_shake_detector_top
// Gravity low-pass, residual energy threshold and jolt counting per sample.
// ----------------------------------------------------------------------------
// One sample beat gives one result beat. Each sample runs a 17-step microcoded
// sequence, left early after the prime step for the priming sample and after
// the compare step for a sample below threshold, that runs every multiplication
// through one shared multiplier: one divide-by-1000 for the time step, three
// for the millisecond stamp (one 16-bit digit each), a filter product and a
// square per axis, and the threshold square. A new sample is taken once the
// sequencer is done, even while the previous result still waits in the output
// register. Configuration writes take effect at once and belong in idle
// periods.

`include "assert_macros.svh"

module accel_shake_detector_top #(
  parameter int unsigned COEFF_TABLE_DEPTH = 256,
  parameter int unsigned SAMPLE_WIDTH      = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]     accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     accel_z_i,
  input  logic [asd_pkg::TimeW-1:0]          time_us_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               primed_o,
  output logic                               over_threshold_o,
  output logic                               shake_event_o,
  output logic [asd_pkg::ResSqW-1:0]         residual_sq_o,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [asd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [asd_pkg::CfgDataW-1:0]       cfg_data_i
);
  import asd_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int GW   = SW + 16;              // gravity, sample scaled by 2^16
  localparam int DW   = GW + 1;               // sample minus gravity
  localparam int RW   = SW + 10;              // residual, Q18.8 at 16-bit samples
  localparam int AccW = 2 * SW + 18;          // sum of three squares
  localparam int AW   = (RW > DivMulW + 1) ? RW : DivMulW + 1;
  localparam int BW   = DW;
  localparam int PW   = AW + BW;
  localparam int IW   = $clog2(COEFF_TABLE_DEPTH);

  // Coefficient table, built at elaboration
  logic [CoefW-1:0] coef_rom [COEFF_TABLE_DEPTH];
  for (genvar n = 0; n < COEFF_TABLE_DEPTH; n++) begin : g_rom
    localparam logic [CoefW-1:0] CoefVal = coeff_entry(n);
    assign coef_rom[n] = CoefVal;
  end

  // Sequencer and persistent state
  logic                  busy_q;
  logic [PcW-1:0]        pc_q, pc_d;
  logic                  filt_primed_q;
  logic [TimeW-1:0]      last_time_q;
  logic signed [GW-1:0]  grav_q [3];
  logic [JoltW-1:0]      jolt_q;
  logic [MsW-1:0]        win_start_q;
  logic [MsW-1:0]        last_shake_q;
  logic [ThrW-1:0]       thr_q;
  logic [WinW-1:0]       win_ms_q;
  logic [JoltW-1:0]      min_jolts_q;
  logic [CoolW-1:0]      cool_q;
  logic [1:0]            dig_q;
  logic [1:0]            ax_q;
  logic                  primed_q, over_q, shake_q;
  logic                  out_valid_q;

  // Working registers
  logic signed [SW-1:0]  samp_q [3];
  logic [TimeW-1:0]      time_q;
  logic [DivXW-1:0]      x_q;
  logic                  dflt_q;
  logic [IW-1:0]         idx_q;
  logic [MsW-1:0]        now_ms_q;
  logic [CoefW-1:0]      coef_q;
  logic signed [DW-1:0]  diff_q;
  logic signed [RW-1:0]  r_q;
  logic [AccW-1:0]       acc_q;
  logic signed [PW-1:0]  prod_q;
  logic [ResSqW-1:0]     res_q;
  logic                  out_primed_q, out_over_q, out_shake_q;
  logic [ResSqW-1:0]     out_res_q;

  // Decode
  ctrl_t ctrl;
  act_e  act;
  mul_e  mul;
  logic  in_fire;
  logic  out_free;
  logic  jmp_taken;

  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign ctrl       = ucode(pc_q);
  assign act        = busy_q ? ctrl.act : ACT_NONE;
  assign mul        = busy_q ? ctrl.mul : MUL_NONE;

  // Time step and ROM index source
  logic [TimeW:0]    dt_full;
  logic              dt_bad;
  logic [DivXW-1:0]  dt_x;

  always_comb begin
    dt_full = {1'b0, time_q} - {1'b0, last_time_q};
    dt_bad  = (last_time_q == '0) || dt_full[TimeW] || (dt_full == '0) ||
              (dt_full[TimeW-1:0] > TimeW'(MaxStepUs));
    dt_x    = DivXW'(dt_full[17:0]) + DivXW'(HalfMsUs);
  end

  // Long division of the timestamp by 1000, one 16-bit digit per pass of the divide and digit steps
  logic [DigitW-1:0] q_dig;
  logic [DivXW-1:0]  q_times;
  logic [DivXW-1:0]  rem_full;
  logic [DigitW-1:0] next_digit;

  always_comb begin
    q_dig    = prod_q[Div1000Shift +: DigitW];
    q_times  = {q_dig, 10'b0} - DivXW'({q_dig, 4'b0}) - DivXW'({q_dig, 3'b0});
    rem_full = x_q - q_times;
    case (dig_q)
      2'd0:    next_digit = time_q[31:16];
      2'd1:    next_digit = time_q[15:0];
      default: next_digit = '0;
    endcase
  end

  // Per-axis filter arithmetic
  logic signed [SW-1:0] samp_cur;
  logic signed [GW-1:0] grav_cur;
  logic signed [GW-1:0] scaled;
  logic signed [DW-1:0] diff_new;
  logic signed [PW-1:0] prod_rnd;
  logic signed [DW-1:0] fstep;
  logic signed [GW-1:0] gnew;
  logic signed [DW:0]   rsum;
  logic signed [RW-1:0] r_new;

  always_comb begin
    samp_cur = samp_q[ax_q];
    grav_cur = grav_q[ax_q];
    scaled   = $signed({samp_cur, 16'b0});
    diff_new = DW'(scaled) - DW'(grav_cur);
    prod_rnd = prod_q + PW'(32768);
    fstep    = DW'(prod_rnd >>> 16);
    gnew     = GW'(DW'(grav_cur) + fstep);
    rsum     = (DW + 1)'(diff_new) + (DW + 1)'(128);
    r_new    = RW'(rsum >>> 8);
  end

  // Shared multiplier operands
  logic signed [AW-1:0] opa;
  logic signed [BW-1:0] opb;

  always_comb begin
    unique case (mul)
      MUL_FILT: begin
        opa = AW'($signed({1'b0, coef_q}));
        opb = BW'(diff_q);
      end
      MUL_SQ: begin
        opa = AW'(r_q);
        opb = BW'(r_q);
      end
      MUL_DIV: begin
        opa = AW'($signed({1'b0, Div1000Mul}));
        opb = BW'($signed({1'b0, x_q}));
      end
      MUL_THR: begin
        opa = AW'($signed({1'b0, thr_q}));
        opb = BW'($signed({1'b0, thr_q}));
      end
      MUL_NONE: begin
        opa = '0;
        opb = '0;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Threshold and jolt decisions
  logic [ResSqW-1:0] sum_sat;
  logic              over_new;
  logic [MsW-1:0]    since_win;
  logic              win_restart;
  logic [JoltW-1:0]  jolt_base;
  logic [JoltW-1:0]  jolt_inc;
  logic [MsW-1:0]    since_shake;
  logic              shake_new;

  always_comb begin
    sum_sat     = (acc_q > AccW'(ResSqMax)) ? ResSqMax : acc_q[ResSqW-1:0];
    over_new    = sum_sat >= prod_q[ResSqW-1:0];
    since_win   = now_ms_q - win_start_q;
    win_restart = (jolt_q == '0) || (since_win > MsW'(win_ms_q));
    jolt_base   = win_restart ? '0 : jolt_q;
    jolt_inc    = (jolt_base == JoltMax) ? JoltMax : jolt_base + 1'b1;
    since_shake = now_ms_q - last_shake_q;
    shake_new   = (jolt_q >= min_jolts_q) && (since_shake > MsW'(cool_q));
  end

  // Next step
  always_comb begin
    unique case (ctrl.jmp)
      JMP_NEXT:       jmp_taken = 1'b0;
      JMP_UNPRIMED:   jmp_taken = !filt_primed_q;
      JMP_DIGIT_MORE: jmp_taken = (dig_q != 2'd2);
      JMP_AXIS_MORE:  jmp_taken = (ax_q != 2'd2);
      JMP_UNDER:      jmp_taken = !over_new;
      JMP_WAIT_OUT:   jmp_taken = !out_free;
      default:        jmp_taken = 1'b0;
    endcase
    pc_d = jmp_taken ? ctrl.target : pc_q + 1'b1;
  end

  // Control and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      pc_q          <= StepDt;
      filt_primed_q <= 1'b0;
      last_time_q   <= '0;
      for (int i = 0; i < 3; i++) grav_q[i] <= '0;
      jolt_q        <= '0;
      win_start_q   <= '0;
      last_shake_q  <= '0;
      thr_q         <= ShakeThrReset;
      win_ms_q      <= WindowMsReset;
      min_jolts_q   <= MinJoltsReset;
      cool_q        <= CooldownMsReset;
      dig_q         <= '0;
      ax_q          <= '0;
      primed_q      <= 1'b0;
      over_q        <= 1'b0;
      shake_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      // sequencer
      if (in_fire) begin
        busy_q <= 1'b1;
        pc_q   <= StepDt;
      end else if (busy_q) begin
        pc_q <= pc_d;
        if (act == ACT_DONE && out_free) busy_q <= 1'b0;
      end

      // result register handshake
      if (act == ACT_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // datapath actions
      case (act)
        ACT_DT: begin
          last_time_q <= time_q;
          primed_q    <= filt_primed_q;
          over_q      <= 1'b0;
          shake_q     <= 1'b0;
        end
        ACT_IDX:   dig_q <= '0;
        ACT_DIGIT: dig_q <= (dig_q == 2'd2) ? 2'd0 : dig_q + 1'b1;
        ACT_PRIME: begin
          ax_q <= '0;
          if (!filt_primed_q) begin
            filt_primed_q <= 1'b1;
            for (int i = 0; i < 3; i++) grav_q[i] <= $signed({samp_q[i], 16'b0});
          end
        end
        ACT_GUPD:  grav_q[ax_q] <= gnew;
        ACT_ACC:   ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
        ACT_CMP:   over_q <= over_new;
        ACT_WIN: begin
          if (win_restart) win_start_q <= now_ms_q;
          jolt_q <= jolt_inc;
        end
        ACT_SHK: begin
          shake_q <= shake_new;
          if (shake_new) begin
            jolt_q       <= '0;
            last_shake_q <= now_ms_q;
          end
        end
        default: ;
      endcase

      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_THRESHOLD: thr_q       <= cfg_data_i[ThrW-1:0];
          CFG_WINDOW:    win_ms_q    <= cfg_data_i[WinW-1:0];
          CFG_MIN_JOLTS: min_jolts_q <= cfg_data_i[JoltW-1:0];
          CFG_COOLDOWN:  cool_q      <= cfg_data_i[CoolW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      samp_q[0] <= accel_x_i;
      samp_q[1] <= accel_y_i;
      samp_q[2] <= accel_z_i;
      time_q    <= time_us_i;
    end

    if (mul != MUL_NONE) prod_q <= opa * opb;

    case (act)
      ACT_DT: begin
        x_q    <= dt_x;
        dflt_q <= dt_bad;
        res_q  <= '0;
      end
      ACT_IDX: begin
        idx_q <= dflt_q ? IW'(DefaultStepMs) : prod_q[Div1000Shift +: IW];
        x_q   <= DivXW'(time_q[47:32]);
      end
      ACT_DIGIT: begin
        now_ms_q <= {now_ms_q[MsW-DigitW-1:0], q_dig};
        x_q      <= {rem_full[RemW-1:0], next_digit};
      end
      ACT_PRIME: begin
        coef_q <= coef_rom[idx_q];
        acc_q  <= '0;
      end
      ACT_DIFF: diff_q <= diff_new;
      ACT_RES:  r_q    <= r_new;
      ACT_ACC:  acc_q  <= acc_q + prod_q[AccW-1:0];
      ACT_CMP:  res_q  <= sum_sat;
      default: ;
    endcase

    if (act == ACT_DONE && out_free) begin
      out_primed_q <= primed_q;
      out_over_q   <= over_q;
      out_shake_q  <= shake_q;
      out_res_q    <= res_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign primed_o         = out_primed_q;
  assign over_threshold_o = out_over_q;
  assign shake_event_o    = out_shake_q;
  assign residual_sq_o    = out_res_q;

  // Checks
  `ASSERT_IMPL(a_pc_range, busy_q, pc_q <= StepDone, "sequencer ran past the last step")
  `ASSERT_IMPL(a_axis_range, busy_q, ax_q <= 2'd2, "axis counter out of range")
  `ASSERT_IMPL(a_digit_range, busy_q, dig_q <= 2'd2, "digit counter out of range")
  `ASSERT_IMPL(a_valid_on_done, $rose(out_valid_q), $fell(busy_q), "result without sequence end")
  `ASSERT_IMPL(a_shake_clears, $rose(shake_q), jolt_q == '0, "shake left jolt count set")
  `ASSERT_IMPL(a_primed_sticky, out_valid_q && out_primed_q, filt_primed_q, "primed result with unprimed filter")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for accel_shake_detector_top: a queue-fed sample driver,
// a result monitor and a cycle-free predictor of the gravity filter, residual
// energy and jolt/shake logic, run over several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import asd_pkg::*;

  localparam int SampleW      = 16;
  localparam int CoefDepth    = 256;
  localparam int SettleCycles = 40;

  typedef struct packed {
    logic signed [SampleW-1:0] ax;
    logic signed [SampleW-1:0] ay;
    logic signed [SampleW-1:0] az;
    logic [TimeW-1:0]          t;
  } sample_t;

  typedef struct packed {
    logic              primed;
    logic              over;
    logic              shake;
    logic [ResSqW-1:0] rsq;
  } shake_res_t;

  // DUT connections
  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] accel_x_i    = '0;
  logic signed [SampleW-1:0] accel_y_i    = '0;
  logic signed [SampleW-1:0] accel_z_i    = '0;
  logic [TimeW-1:0]          time_us_i    = '0;
  logic                      out_valid_o;
  logic                      out_ready_i  = 1'b0;
  logic                      primed_o;
  logic                      over_threshold_o;
  logic                      shake_event_o;
  logic [ResSqW-1:0]         residual_sq_o;
  logic                      cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index_i  = '0;
  logic [CfgDataW-1:0]       cfg_data_i   = '0;

  // Stimulus and scoreboard
  sample_t    sample_q[$];
  shake_res_t expect_q[$];
  int         in_issue_cnt = 0;
  int         in_acc_cnt   = 0;
  int         in_gap       = 0;
  int         out_stall    = 0;
  int         n_errors     = 0;
  bit         idle_on      = 1'b0;
  logic [TimeW-1:0] t_cursor = '0;

  // Predictor configuration and state
  logic [ThrW-1:0]  thr_cfg       = ShakeThrReset;
  logic [WinW-1:0]  win_cfg       = WindowMsReset;
  logic [JoltW-1:0] min_jolts_cfg = MinJoltsReset;
  logic [CoolW-1:0] cool_cfg      = CooldownMsReset;
  logic [CoefW-1:0] coeff_lut[CoefDepth];
  longint           grav_q24[3]   = '{0, 0, 0};
  bit               filt_primed   = 1'b0;
  logic [TimeW-1:0] prev_stamp_us = '0;
  logic [JoltW-1:0] jolt_cnt      = '0;
  logic [MsW-1:0]   win_start_ms  = '0;
  logic [MsW-1:0]   last_shake_ms = '0;

  accel_shake_detector_top #(
    .COEFF_TABLE_DEPTH(CoefDepth),
    .SAMPLE_WIDTH     (SampleW)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .accel_z_i       (accel_z_i),
    .time_us_i       (time_us_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .primed_o        (primed_o),
    .over_threshold_o(over_threshold_o),
    .shake_event_o   (shake_event_o),
    .residual_sq_o   (residual_sq_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // floor((x + 2^(s-1)) / 2^s)
  function automatic longint round_shr(input longint x, input int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Expected result of one sample; advances the predictor state
  function automatic shake_res_t predict_shake(input sample_t s);
    shake_res_t       r;
    longint           acc[3];
    longint           scaled;
    longint           resid;
    longint           sum;
    longint           k;
    logic [TimeW-1:0] dt_us;
    logic [TimeW-1:0] t_ms;
    logic [MsW-1:0]   now_ms;
    logic [MsW-1:0]   since;
    int               idx;
    acc[0] = longint'($signed(s.ax));
    acc[1] = longint'($signed(s.ay));
    acc[2] = longint'($signed(s.az));
    dt_us = s.t - prev_stamp_us;
    if (prev_stamp_us == '0 || s.t <= prev_stamp_us || dt_us > TimeW'(MaxStepUs)) begin
      idx = DefaultStepMs;
    end else begin
      idx = int'((64'(dt_us) + 64'(HalfMsUs)) / 64'd1000);
    end
    prev_stamp_us = s.t;
    r = '{primed: filt_primed, over: 1'b0, shake: 1'b0, rsq: '0};
    // priming sample loads gravity and leaves jolt logic alone
    if (!filt_primed) begin
      for (int i = 0; i < 3; i++) grav_q24[i] = acc[i] * 65536;
      filt_primed = 1'b1;
      return r;
    end
    // low-pass update and residual energy
    k = longint'(coeff_lut[idx]);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      scaled = acc[i] * 65536;
      grav_q24[i] = grav_q24[i] + round_shr(k * (scaled - grav_q24[i]), 16);
      resid = round_shr(scaled - grav_q24[i], 8);
      if (resid < 0) resid = -resid;
      sum = sum + resid * resid;
    end
    if (sum > longint'(ResSqMax)) sum = longint'(ResSqMax);
    r.rsq = sum[ResSqW-1:0];
    if (sum < longint'(thr_cfg) * longint'(thr_cfg)) return r;
    r.over = 1'b1;
    // jolt window and shake decision
    t_ms = s.t / TimeW'(1000);
    now_ms = t_ms[MsW-1:0];
    since = now_ms - win_start_ms;
    if (jolt_cnt == '0 || since > MsW'(win_cfg)) begin
      win_start_ms = now_ms;
      jolt_cnt = '0;
    end
    if (jolt_cnt != JoltMax) jolt_cnt = jolt_cnt + 1'b1;
    since = now_ms - last_shake_ms;
    if (jolt_cnt >= min_jolts_cfg && since > MsW'(cool_cfg)) begin
      jolt_cnt = '0;
      last_shake_ms = now_ms;
      r.shake = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string field, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      n_errors++;
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
    end
  endtask

  // Monitor first, then prediction of the beat accepted at the same edge
  always @(posedge clk_i) begin : mon_blk
    shake_res_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expect_q.size() == 0) begin
          n_errors++;
          $error("result beat with no pending expectation");
        end else begin
          exp_r = expect_q.pop_front();
          check_field("primed", exp_r.primed, primed_o);
          check_field("over_threshold", exp_r.over, over_threshold_o);
          check_field("shake_event", exp_r.shake, shake_event_o);
          check_field("residual_sq", exp_r.rsq, residual_sq_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        expect_q.push_back(predict_shake('{ax: accel_x_i, ay: accel_y_i,
                                           az: accel_z_i, t: time_us_i}));
        in_acc_cnt++;
      end
    end
  end

  // Sample driver
  always @(negedge clk_i) begin : drv_blk
    sample_t s;
    if (rst_ni && (!in_valid_i || in_acc_cnt == in_issue_cnt)) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (sample_q.size() != 0) begin
        s = sample_q.pop_front();
        accel_x_i  <= s.ax;
        accel_y_i  <= s.ay;
        accel_z_i  <= s.az;
        time_us_i  <= s.t;
        in_valid_i <= 1'b1;
        in_issue_cnt++;
        if (idle_on && $urandom_range(0, 99) < 15) in_gap = $urandom_range(1, 14);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall != 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_on && $urandom_range(0, 99) < 12) out_stall = $urandom_range(1, 14);
      end
    end
  end

  task automatic queue_sample(input int ax, input int ay, input int az,
                              input logic [TimeW-1:0] t);
    sample_q.push_back('{ax: SampleW'(ax), ay: SampleW'(ay), az: SampleW'(az), t: t});
  endtask

  function automatic logic signed [SampleW-1:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return SampleW'(v);
  endfunction

  // Mostly realistic motion: small steps, gravity on z, occasional jolts
  function automatic sample_t gen_sample();
    sample_t     s;
    int unsigned mode;
    longint      v[3];
    mode = $urandom_range(0, 99);
    if (mode < 82)      t_cursor = t_cursor + TimeW'($urandom_range(500, 12000));
    else if (mode < 88) t_cursor = t_cursor + TimeW'($urandom_range(12000, 260000));
    else if (mode < 91) t_cursor = t_cursor;
    else if (mode < 94) t_cursor = t_cursor - TimeW'($urandom_range(1, 50000));
    else if (mode < 96) t_cursor = {16'($urandom), 32'($urandom)};
    else                t_cursor = t_cursor + TimeW'(199000 + $urandom_range(0, 2000));
    s.t = t_cursor;
    mode = $urandom_range(0, 99);
    v[0] = 0;
    v[1] = 0;
    v[2] = 2509;
    for (int i = 0; i < 3; i++) begin
      v[i] = v[i] + longint'($urandom_range(0, 600)) - 300;
      if (mode < 22) v[i] = v[i] + longint'($urandom_range(0, 40000)) - 20000;
    end
    s.ax = clamp16(v[0]);
    s.ay = clamp16(v[1]);
    s.az = clamp16(v[2]);
    if (mode >= 95) begin
      s.ax = SampleW'($urandom);
      s.ay = SampleW'($urandom);
      s.az = SampleW'($urandom);
    end
    return s;
  endfunction

  // Wait until every queued beat has its result, then let the block settle
  task automatic wait_idle();
    @(negedge clk_i);
    while (sample_q.size() != 0 || in_acc_cnt != in_issue_cnt || expect_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_THRESHOLD: thr_cfg       = val[ThrW-1:0];
      CFG_WINDOW:    win_cfg       = val[WinW-1:0];
      CFG_MIN_JOLTS: min_jolts_cfg = val[JoltW-1:0];
      CFG_COOLDOWN:  cool_cfg      = val[CoolW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [CfgDataW-1:0] thr, input logic [CfgDataW-1:0] win,
                              input logic [CfgDataW-1:0] minj,
                              input logic [CfgDataW-1:0] cool);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_MIN_JOLTS, minj);
    write_reg(CFG_COOLDOWN, cool);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int n);
    repeat (n) sample_q.push_back(gen_sample());
    wait_idle();
  endtask

  // Run limit
  initial begin
    #6_000_000;
    $display("accel_shake_detector_top test failed");
    $finish;
  end

  // Main sequence
  initial begin : main_seq
    logic [63:0] ratio_p;
    logic [63:0] coef;
    // coefficient table: 1 - R^n by rounded recurrence
    ratio_p = 64'h1_0000_0000;
    for (int n = 0; n < CoefDepth; n++) begin
      coef = (64'h1_0000_0000 - ratio_p + 64'd32768) >> 16;
      coeff_lut[n] = (coef > 64'd65535) ? {CoefW{1'b1}} : coef[CoefW-1:0];
      ratio_p = (ratio_p * CoeffRatioQ32 + 64'h8000_0000) >> 32;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_on = 1'b1;

    // Directed: priming at stamp zero, step corner cases, extremes
    queue_sample(-32768, 32767, -32768, 48'd0);
    queue_sample(32767, -32768, 32767, 48'd1000);       // no prior stamp
    queue_sample(0, 0, 0, 48'd1000);                    // equal stamp
    queue_sample(0, 0, 0, 48'd1499);                    // rounds to zero ms
    queue_sample(-32768, -32768, -32768, 48'd1999);     // half ms rounds up
    queue_sample(0, 0, 2509, 48'd201999);               // exactly max step
    queue_sample(0, 0, 2509, 48'd402000);               // just over max step
    queue_sample(100, -100, 2509, 48'd300000);          // stamp goes back
    queue_sample(32767, 32767, 32767, {TimeW{1'b1}});   // largest stamp
    queue_sample(-1, -1, -1, 48'd5);                    // wrap back to small
    // jolt burst past cooldown: shake on the third
    queue_sample(20000, -20000, 20000, 48'd2000000);
    queue_sample(-20000, 20000, -20000, 48'd2010000);
    queue_sample(20000, -20000, 20000, 48'd2020000);
    // more jolts inside the cooldown
    queue_sample(-20000, 20000, -20000, 48'd2030000);
    queue_sample(20000, -20000, 20000, 48'd2040000);
    queue_sample(-20000, 20000, -20000, 48'd2050000);
    queue_sample(-20000, 20000, -20000, 48'd2054000);   // near gravity, may stay low
    // window runs out, count restarts, then a new shake
    queue_sample(20000, -20000, 20000, 48'd3000000);
    queue_sample(-20000, 20000, -20000, 48'd3010000);
    queue_sample(20000, -20000, 20000, 48'd3020000);
    t_cursor = 48'd3020000;
    wait_idle();

    // Random phases over several settings
    run_random(300);
    apply_config(16'd0, 16'd0, 16'd1, 16'd0);
    run_random(200);
    apply_config(16'hFFFF, 16'hFFFF, 16'd255, 16'hFFFF);
    run_random(200);
    apply_config(16'd1000, 16'd100, 16'd0, 16'd50);
    run_random(250);
    apply_config(16'd2000, 16'd300, 16'd2, 16'd200);
    run_random(300);
    // closing stretch at full rate
    apply_config(16'(ShakeThrReset), WindowMsReset, 16'(MinJoltsReset), CooldownMsReset);
    idle_on = 1'b0;
    run_random(150);

    if (n_errors == 0) begin
      $display("accel_shake_detector_top test passed");
    end else begin
      $display("accel_shake_detector_top test failed");
    end
    $finish;
  end

endmodule
